// ----- sv/chdq_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the character deque: field widths, command and
// status codes, register indexes, and the control word that drives the cells.
// No dependencies.
package chdq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int LEN_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_PUSH_MID   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_POP_MID    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_WRITE      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_READ       = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SET_LEN    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_REINIT     = 4'd9;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BYTE   = 1'd1;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_WRITE,
      CELL_FILL
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [BYTE_W-1:0]  value;
      logic [BYTE_W-1:0]  fill;
   } cell_ctrl_type;

endpackage

// ----- sv/chdq_req_if.sv -----
`timescale 1ns / 1ps
// Command channel of the character deque: valid/ready plus one command word.
// Depends on chdq_pkg for field widths.
interface chdq_req_if;
   logic                          valid;
   logic                          ready;
   logic [chdq_pkg::CMD_W-1:0]    cmd;
   logic [chdq_pkg::BYTE_W-1:0]   value;
   logic [chdq_pkg::POS_W-1:0]    position;
   logic [chdq_pkg::LEN_W-1:0]    new_length;

   modport source (output valid, cmd, value, position, new_length, input ready);
   modport sink   (input valid, cmd, value, position, new_length, output ready);
endinterface

// ----- sv/chdq_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the character deque: valid/ready plus one result word.
// Depends on chdq_pkg for field widths.
interface chdq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [chdq_pkg::BYTE_W-1:0]     read_byte;
   logic [chdq_pkg::LEN_W-1:0]      fill_level;
   logic [chdq_pkg::STATUS_W-1:0]   status;

   modport source (output valid, read_byte, fill_level, status, input ready);
   modport sink   (input valid, read_byte, fill_level, status, output ready);
endinterface

// ----- sv/chdq_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the deque row: holds a single byte and takes a new one
// from its neighbors, the command value or the fill byte. Depends on chdq_pkg.
module chdq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chdq_pkg::cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]              lo,
   input  logic [CNT_W-1:0]              hi,
   input  logic [chdq_pkg::BYTE_W-1:0]   left_q,
   input  logic [chdq_pkg::BYTE_W-1:0]   right_q,
   output logic [chdq_pkg::BYTE_W-1:0]   q
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [chdq_pkg::BYTE_W-1:0] data_ff;
   logic [chdq_pkg::BYTE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         chdq_pkg::CELL_SHIFT_UP: begin
            // insertion point takes the new byte, cells above it take the lower neighbor
            if (IDX == lo) begin
               data_in = ctrl.value;
            end else if (IDX > lo && IDX <= hi) begin
               data_in = left_q;
            end
         end
         chdq_pkg::CELL_SHIFT_DOWN: begin
            if (IDX >= lo && IDX < hi) begin
               data_in = right_q;
            end
         end
         chdq_pkg::CELL_WRITE: begin
            if (IDX == lo) begin
               data_in = ctrl.value;
            end
         end
         chdq_pkg::CELL_FILL: begin
            data_in = ctrl.fill;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

// ----- sv/char_deque_with_mid_ops.sv -----
`timescale 1ns / 1ps
// Bounded byte deque with middle insert and removal. Takes one command word
// per cycle and returns one result word for each, through a pipeline stage
// and then the result register; these let commands stream back to back as
// long as the result side keeps taking words. Every entry lives in its own
// cell of a row, and push/pop at front, back or middle move all affected
// entries by one place at once, so no command takes longer than the others.
// A read selects its entry in eight-cell groups that are registered, then
// merges the groups into the result register. Configuration (init_length,
// fill_byte) must be written through the csr_ port only while no command is
// in flight; the block itself does not enforce this. Reset clears all
// entries, the length and both registers.
module char_deque_with_mid_ops #(
   parameter int DEPTH = chdq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   chdq_req_if.sink                          req_chan,
   chdq_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [chdq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [chdq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > chdq_pkg::LEN_W) ? CNT_W : chdq_pkg::LEN_W;
   localparam int GROUP  = 8;
   localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;
   localparam int NPAD   = NGROUP * GROUP;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   // configuration registers
   logic [chdq_pkg::LEN_W-1:0]  init_length_ff;
   logic [chdq_pkg::BYTE_W-1:0] fill_byte_ff;

   // length and pipeline state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             a_valid_ff, a_valid_in;
   logic [chdq_pkg::LEN_W-1:0]    a_fill_ff;
   logic [chdq_pkg::STATUS_W-1:0] a_status_ff;
   logic [chdq_pkg::BYTE_W-1:0]   group_ff [NGROUP];
   logic [chdq_pkg::BYTE_W-1:0]   group_in [NGROUP];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [chdq_pkg::BYTE_W-1:0]   rsp_read_ff, rsp_read_in;
   logic [chdq_pkg::LEN_W-1:0]    rsp_fill_ff;
   logic [chdq_pkg::STATUS_W-1:0] rsp_status_ff;

   // handshake
   logic out_free, a_advance, req_ready, req_fire;

   // decode results
   chdq_pkg::cell_ctrl_type        ctrl;
   logic [CNT_W-1:0]               lo, hi;
   logic [chdq_pkg::STATUS_W-1:0]  status;
   logic                           rd_good;
   logic [CMP_W-1:0]               count_cmp, pos_cmp, nlen_cmp, init_cmp;
   logic                           full, empty;

   // cell row
   logic [chdq_pkg::BYTE_W-1:0] cell_q [NPAD];
   logic                        sel [NPAD];

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign a_advance = a_valid_ff && out_free;
   assign req_ready = !a_valid_ff || out_free;
   assign req_fire  = req_chan.valid && req_ready;

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_byte  = rsp_read_ff;
   assign rsp_chan.fill_level = rsp_fill_ff;
   assign rsp_chan.status     = rsp_status_ff;

   assign count_cmp = CMP_W'(count_ff);
   assign pos_cmp   = CMP_W'(req_chan.position);
   assign nlen_cmp  = CMP_W'(req_chan.new_length);
   assign init_cmp  = CMP_W'(init_length_ff);
   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);

   // Decode the command into one broadcast cell operation with its bounds,
   // the next length and the status. Cell ops are dropped unless accepted.
   always_comb begin
      ctrl.op    = chdq_pkg::CELL_HOLD;
      ctrl.value = req_chan.value;
      ctrl.fill  = fill_byte_ff;
      lo         = '0;
      hi         = '0;
      count_in   = count_ff;
      status     = chdq_pkg::ST_OK;
      rd_good    = 1'b0;
      unique case (req_chan.cmd)
         chdq_pkg::CMD_PUSH_BACK, chdq_pkg::CMD_PUSH_FRONT, chdq_pkg::CMD_PUSH_MID: begin
            if (full) begin
               status = chdq_pkg::ST_REFUSED;
            end else begin
               ctrl.op  = chdq_pkg::CELL_SHIFT_UP;
               hi       = count_ff;
               count_in = count_ff + 1'b1;
               if (req_chan.cmd == chdq_pkg::CMD_PUSH_BACK) begin
                  lo = count_ff;
               end else if (req_chan.cmd == chdq_pkg::CMD_PUSH_MID) begin
                  // insertion point is (count + 1) / 2
                  lo = (count_ff >> 1) + CNT_W'(count_ff[0]);
               end
            end
         end
         chdq_pkg::CMD_POP_BACK: begin
            if (empty) begin
               status = chdq_pkg::ST_REFUSED;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         chdq_pkg::CMD_POP_FRONT, chdq_pkg::CMD_POP_MID: begin
            if (empty) begin
               status = chdq_pkg::ST_REFUSED;
            end else begin
               ctrl.op  = chdq_pkg::CELL_SHIFT_DOWN;
               hi       = count_ff - 1'b1;
               count_in = count_ff - 1'b1;
               if (req_chan.cmd == chdq_pkg::CMD_POP_MID) begin
                  lo = count_ff >> 1;
               end
            end
         end
         chdq_pkg::CMD_WRITE: begin
            if (pos_cmp >= count_cmp) begin
               status = chdq_pkg::ST_BADPOS;
            end else begin
               ctrl.op = chdq_pkg::CELL_WRITE;
               lo      = CNT_W'(req_chan.position);
            end
         end
         chdq_pkg::CMD_READ: begin
            if (pos_cmp >= count_cmp) begin
               status = chdq_pkg::ST_BADPOS;
            end else begin
               rd_good = 1'b1;
            end
         end
         chdq_pkg::CMD_SET_LEN: begin
            if (nlen_cmp > DEPTH_CMP) begin
               status = chdq_pkg::ST_BADPOS;
            end else begin
               count_in = CNT_W'(req_chan.new_length);
            end
         end
         chdq_pkg::CMD_REINIT: begin
            if (init_cmp > DEPTH_CMP) begin
               status = chdq_pkg::ST_BADPOS;
            end else begin
               ctrl.op  = chdq_pkg::CELL_FILL;
               count_in = CNT_W'(init_length_ff);
            end
         end
         default: begin
            // unused codes change nothing
            status = chdq_pkg::ST_OK;
         end
      endcase
      if (!req_fire) begin
         ctrl.op  = chdq_pkg::CELL_HOLD;
         count_in = count_ff;
      end
   end

   // Row of cells; each sees its neighbors' bytes and the broadcast op.
   for (genvar i = 0; i < NPAD; i++) begin : g_row
      if (i < DEPTH) begin : g_cell
         logic [chdq_pkg::BYTE_W-1:0] left_q, right_q;
         if (i == 0) begin : g_first
            assign left_q = '0;
         end else begin : g_inner_l
            assign left_q = cell_q[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_q = '0;
         end else begin : g_inner_r
            assign right_q = cell_q[i+1];
         end
         chdq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .lo      (lo),
            .hi      (hi),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[i])
         );
         assign sel[i] = rd_good && (pos_cmp == CMP_W'(i));
      end else begin : g_pad
         assign cell_q[i] = '0;
         assign sel[i]    = 1'b0;
      end
   end

   // First read level: merge each group of eight cells.
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            if (sel[g*GROUP + j]) begin
               group_in[g] = group_in[g] | cell_q[g*GROUP + j];
            end
         end
      end
   end

   // Second read level: merge the registered groups.
   always_comb begin
      rsp_read_in = '0;
      for (int g = 0; g < NGROUP; g++) begin
         rsp_read_in = rsp_read_in | group_ff[g];
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (a_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state: config, length and stage valids, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_length_ff <= '0;
         fill_byte_ff   <= '0;
         count_ff       <= '0;
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == chdq_pkg::CSR_INIT_LENGTH) begin
               init_length_ff <= chdq_pkg::LEN_W'(csr_wdata);
            end else if (csr_index == chdq_pkg::CSR_FILL_BYTE) begin
               fill_byte_ff <= csr_wdata;
            end
         end
         count_ff     <= count_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture the accepted word's results, then advance to the output.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_fill_ff   <= chdq_pkg::LEN_W'(count_in);
         a_status_ff <= status;
         for (int g = 0; g < NGROUP; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
      if (a_advance) begin
         rsp_read_ff   <= rsp_read_in;
         rsp_fill_ff   <= a_fill_ff;
         rsp_status_ff <= a_status_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("length exceeds depth");

   a_pop_back_len: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.cmd == chdq_pkg::CMD_POP_BACK && !empty)
      |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("pop back did not shorten the deque by one");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != chdq_pkg::ST_OK) |-> rsp_read_ff == '0)
      else $error("read byte set on a failed command");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending word did not reach the output register");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for char_deque_with_mid_ops: random and directed command
// words against an in-bench deque predictor. Depends on chdq_pkg, chdq_req_if,
// chdq_rsp_if and the char_deque_with_mid_ops RTL.
module tb;

   localparam int DEPTH        = chdq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   // margin on top of the time the block takes to answer after acceptance
   localparam int SETTLE_CYCLES = 6;
   // command codes the block decodes as no-ops
   localparam logic [chdq_pkg::CMD_W-1:0] CMD_SPARE_LO = 4'd10;
   localparam logic [chdq_pkg::CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   typedef struct {
      logic [chdq_pkg::CMD_W-1:0]  cmd;
      logic [chdq_pkg::BYTE_W-1:0] value;
      logic [chdq_pkg::POS_W-1:0]  position;
      logic [chdq_pkg::LEN_W-1:0]  new_length;
   } cmd_word_type;

   typedef struct {
      logic [chdq_pkg::BYTE_W-1:0]   read_byte;
      logic [chdq_pkg::LEN_W-1:0]    fill_level;
      logic [chdq_pkg::STATUS_W-1:0] status;
   } rsp_word_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [chdq_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [chdq_pkg::CSR_DATA_W-1:0] csr_wdata;

   chdq_req_if req_bus ();
   chdq_rsp_if rsp_bus ();

   char_deque_with_mid_ops #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the deque contents, length and the two registers.
   logic [chdq_pkg::BYTE_W-1:0] mirror_bytes [DEPTH];
   int unsigned                 mirror_len;
   logic [chdq_pkg::LEN_W-1:0]  mirror_init_len;
   logic [chdq_pkg::BYTE_W-1:0] mirror_fill;

   cmd_word_type pending_words[$];   // command words not yet offered
   rsp_word_type expected_words[$];  // predicted result words, oldest first
   cmd_word_type held_word;          // word currently on the request channel
   int           send_gap;
   int           stall_left;
   bit           calm;               // suppress all idling in the last phase
   int           fails;
   int           cycle_count;

   // Apply one command word to the mirror and return the result word it gives.
   function automatic rsp_word_type deque_apply(cmd_word_type w);
      rsp_word_type r;
      int           i;
      int           mid;
      r.read_byte = '0;
      r.status    = chdq_pkg::ST_OK;
      case (w.cmd)
         chdq_pkg::CMD_PUSH_BACK, chdq_pkg::CMD_PUSH_FRONT, chdq_pkg::CMD_PUSH_MID: begin
            if (mirror_len >= DEPTH) begin
               r.status = chdq_pkg::ST_REFUSED;
            end else begin
               // landing slot: back, front, or middle of the grown sequence
               if (w.cmd == chdq_pkg::CMD_PUSH_BACK) mid = mirror_len;
               else if (w.cmd == chdq_pkg::CMD_PUSH_FRONT) mid = 0;
               else mid = (mirror_len + 1) / 2;
               for (i = mirror_len; i > mid; i--) mirror_bytes[i] = mirror_bytes[i-1];
               mirror_bytes[mid] = w.value;
               mirror_len++;
            end
         end
         chdq_pkg::CMD_POP_BACK, chdq_pkg::CMD_POP_FRONT, chdq_pkg::CMD_POP_MID: begin
            if (mirror_len == 0) begin
               r.status = chdq_pkg::ST_REFUSED;
            end else begin
               if (w.cmd == chdq_pkg::CMD_POP_BACK) mid = mirror_len - 1;
               else if (w.cmd == chdq_pkg::CMD_POP_FRONT) mid = 0;
               else mid = mirror_len / 2;
               for (i = mid; i + 1 < mirror_len; i++) mirror_bytes[i] = mirror_bytes[i+1];
               mirror_len--;
            end
         end
         chdq_pkg::CMD_WRITE: begin
            if (w.position >= mirror_len) r.status = chdq_pkg::ST_BADPOS;
            else mirror_bytes[w.position] = w.value;
         end
         chdq_pkg::CMD_READ: begin
            if (w.position >= mirror_len) r.status = chdq_pkg::ST_BADPOS;
            else r.read_byte = mirror_bytes[w.position];
         end
         chdq_pkg::CMD_SET_LEN: begin
            // storage is left alone, so a regrown tail shows old bytes
            if (w.new_length > DEPTH) r.status = chdq_pkg::ST_BADPOS;
            else mirror_len = int'(w.new_length);
         end
         chdq_pkg::CMD_REINIT: begin
            if (mirror_init_len > DEPTH) begin
               r.status = chdq_pkg::ST_BADPOS;
            end else begin
               for (i = 0; i < DEPTH; i++) mirror_bytes[i] = mirror_fill;
               mirror_len = int'(mirror_init_len);
            end
         end
         default: ;
      endcase
      r.fill_level = chdq_pkg::LEN_W'(mirror_len);
      return r;
   endfunction

   function automatic cmd_word_type make_cmd(logic [chdq_pkg::CMD_W-1:0]  cmd,
                                             logic [chdq_pkg::BYTE_W-1:0] value,
                                             logic [chdq_pkg::POS_W-1:0]  position,
                                             logic [chdq_pkg::LEN_W-1:0]  new_length);
      cmd_word_type w;
      w.cmd        = cmd;
      w.value      = value;
      w.position   = position;
      w.new_length = new_length;
      return w;
   endfunction

   // Weighted random command: pushes slightly outnumber pops so the deque
   // drifts toward full, while set length and reinit pull it back.
   function automatic cmd_word_type random_cmd();
      cmd_word_type w;
      int           pick;
      pick         = $urandom_range(0, 99);
      w.value      = chdq_pkg::BYTE_W'($urandom_range(0, 255));
      w.position   = ($urandom_range(0, 2) == 0) ? chdq_pkg::POS_W'($urandom_range(0, 63))
                                                 : chdq_pkg::POS_W'($urandom_range(0, 15));
      w.new_length = ($urandom_range(0, 4) == 0) ? chdq_pkg::LEN_W'($urandom_range(65, 127))
                                                 : chdq_pkg::LEN_W'($urandom_range(0, 64));
      if (pick < 14)      w.cmd = chdq_pkg::CMD_PUSH_BACK;
      else if (pick < 24) w.cmd = chdq_pkg::CMD_POP_BACK;
      else if (pick < 36) w.cmd = chdq_pkg::CMD_PUSH_FRONT;
      else if (pick < 46) w.cmd = chdq_pkg::CMD_POP_FRONT;
      else if (pick < 58) w.cmd = chdq_pkg::CMD_PUSH_MID;
      else if (pick < 68) w.cmd = chdq_pkg::CMD_POP_MID;
      else if (pick < 76) w.cmd = chdq_pkg::CMD_WRITE;
      else if (pick < 86) w.cmd = chdq_pkg::CMD_READ;
      else if (pick < 91) w.cmd = chdq_pkg::CMD_SET_LEN;
      else if (pick < 96) w.cmd = chdq_pkg::CMD_REINIT;
      else                w.cmd = chdq_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      return w;
   endfunction

   // Write one configuration register; the block must be idle.
   task automatic write_reg(input logic [chdq_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [chdq_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == chdq_pkg::CSR_INIT_LENGTH) mirror_init_len = data[chdq_pkg::LEN_W-1:0];
      else mirror_fill = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued word is sent and every result has come back,
   // then let the pipeline settle.
   task automatic drain();
      @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random(int n);
      int k;
      for (k = 0; k < n; k++) pending_words.push_back(random_cmd());
   endtask

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("char_deque_with_mid_ops: mismatch");
         $finish;
      end
   end

   // Driver: offer one word at a time from pending_words. Predict each word at
   // the edge that accepts it, then either idle for a random burst or advance
   // to the next word. A word on the channel is held until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) expected_words.push_back(deque_apply(held_word));
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               // idle burst of random length, this one included
               send_gap = $urandom_range(1, 19) - 1;
               req_bus.valid <= 1'b0;
            end else begin
               held_word = pending_words.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.cmd        <= held_word.cmd;
               req_bus.value      <= held_word.value;
               req_bus.position   <= held_word.position;
               req_bus.new_length <= held_word.new_length;
            end
         end
      end
   end

   // Monitor: compare each taken result word with the oldest prediction and
   // stall the result side in random bursts.
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no command outstanding: %0d %0d %0d",
                      rsp_bus.read_byte, rsp_bus.fill_level, rsp_bus.status);
               fails++;
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_bus.read_byte !== exp_word.read_byte) begin
                  $error("read_byte: expected %0d, actual %0d",
                         exp_word.read_byte, rsp_bus.read_byte);
                  fails++;
               end
               if (rsp_bus.fill_level !== exp_word.fill_level) begin
                  $error("fill_level: expected %0d, actual %0d",
                         exp_word.fill_level, rsp_bus.fill_level);
                  fails++;
               end
               if (rsp_bus.status !== exp_word.status) begin
                  $error("status: expected %0d, actual %0d", exp_word.status, rsp_bus.status);
                  fails++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Sequence: reset, directed corner cases, then random phases under
   // different register settings. Every phase drains fully before the next
   // register write, which also gives the sender a pause with nothing pending.
   initial begin
      int i;
      // drive every input to a known value from time zero
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = chdq_pkg::CSR_INIT_LENGTH;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = chdq_pkg::CMD_PUSH_BACK;
      req_bus.value      = '0;
      req_bus.position   = '0;
      req_bus.new_length = '0;
      rsp_bus.ready      = 1'b0;
      calm               = 1'b0;
      fails              = 0;
      cycle_count        = 0;
      send_gap           = 0;
      stall_left         = 0;
      mirror_len         = 0;
      mirror_init_len    = '0;
      mirror_fill        = '0;
      for (i = 0; i < DEPTH; i++) mirror_bytes[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty refusals, bad positions, middle insert/remove, full
      // refusals, length limits and spare codes. Registers still at reset.
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_BACK,   8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_FRONT,  8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_MID,    8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_READ,       8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_WRITE,      8'hFF, 6'd63, 7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_REINIT,     8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_MID,   8'h11, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_BACK,  8'hFF, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_FRONT, 8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_MID,   8'hA5, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_MID,   8'h5A, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_MID,    8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_WRITE,      8'hC3, 6'd1,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_READ,       8'h00, 6'd1,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_READ,       8'h00, 6'd3,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_READ,       8'h00, 6'd4,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_FRONT,  8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_SET_LEN,    8'h00, 6'd0,  7'd64));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_READ,       8'h00, 6'd63, 7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_WRITE,      8'h96, 6'd63, 7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_BACK,  8'h01, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_FRONT, 8'h02, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_PUSH_MID,   8'h03, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_SET_LEN,    8'h00, 6'd0,  7'd65));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_SET_LEN,    8'h00, 6'd0,  7'd127));
      pending_words.push_back(make_cmd(CMD_SPARE_LO,             8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(CMD_SPARE_HI,             8'hFF, 6'd63, 7'd127));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_SET_LEN,    8'h00, 6'd0,  7'd0));
      pending_words.push_back(make_cmd(chdq_pkg::CMD_POP_MID,    8'h00, 6'd0,  7'd0));
      drain();

      // full-size reinit with an all-ones fill
      write_reg(chdq_pkg::CSR_INIT_LENGTH, 8'd64);
      write_reg(chdq_pkg::CSR_FILL_BYTE, 8'hFF);
      queue_random(70);
      drain();

      // largest register value: every reinit is refused
      write_reg(chdq_pkg::CSR_INIT_LENGTH, 8'd127);
      write_reg(chdq_pkg::CSR_FILL_BYTE, 8'h00);
      queue_random(60);
      drain();

      // reinit to empty
      write_reg(chdq_pkg::CSR_INIT_LENGTH, 8'd0);
      write_reg(chdq_pkg::CSR_FILL_BYTE, 8'h5A);
      queue_random(60);
      drain();

      // one past the limit
      write_reg(chdq_pkg::CSR_INIT_LENGTH, 8'd65);
      write_reg(chdq_pkg::CSR_FILL_BYTE, chdq_pkg::CSR_DATA_W'($urandom_range(0, 255)));
      queue_random(50);
      drain();

      write_reg(chdq_pkg::CSR_INIT_LENGTH, chdq_pkg::CSR_DATA_W'($urandom_range(1, 63)));
      write_reg(chdq_pkg::CSR_FILL_BYTE, chdq_pkg::CSR_DATA_W'($urandom_range(0, 255)));
      queue_random(80);
      drain();

      // last phase runs at full rate on both sides
      write_reg(chdq_pkg::CSR_INIT_LENGTH, chdq_pkg::CSR_DATA_W'($urandom_range(0, 64)));
      write_reg(chdq_pkg::CSR_FILL_BYTE, chdq_pkg::CSR_DATA_W'($urandom_range(0, 255)));
      calm = 1'b1;
      queue_random(80);
      drain();

      if (fails == 0) begin
         $display("char_deque_with_mid_ops: match");
      end else begin
         $display("char_deque_with_mid_ops: mismatch");
      end
      $finish;
   end

endmodule
